FILE: rtl/lbs_pkg.sv
package lbs_pkg;

  localparam int MAX_JOINTS = 64;
  localparam int JW         = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int IN_W       = 328;
  localparam int OUT_W      = 192;
  localparam int IQ_DEPTH   = 4;
  localparam int OQ_DEPTH   = 4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SKIN = 1'b1
  } op_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] load_value;
    logic [4:0]  load_slot;
    logic [5:0]  load_joint;
    logic [63:0] weight_set;
    logic [23:0] joint_set;
    logic [2:0][31:0] nrm;
    logic [2:0][31:0] pos;
  } item_t;

  typedef struct packed {
    logic        vld;
    logic        first;
    logic        last;
    logic [15:0] wt;
    logic [2:0][31:0] nrm;
    logic [2:0][31:0] pos;
  } tag_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [47:0] rnd16(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd32768;
    return t[63:16];
  endfunction

  function automatic logic signed [36:0] rnd15(input logic signed [51:0] v);
    logic signed [51:0] t;
    t = v + 52'sd16384;
    return t[51:15];
  endfunction

endpackage

FILE: rtl/lbs_front.sv
module lbs_front import lbs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            in_tuser,
  output logic            q_valid,
  input  logic            q_pop,
  output item_t           q_item
);

  localparam int PW = $clog2(IQ_DEPTH);

  item_t           mem_r [IQ_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  item_t           in_item;
  logic            push;

  always_comb begin
    in_item.opcode     = op_t'(in_tuser);
    in_item.pos[0]     = in_tdata[31:0];
    in_item.pos[1]     = in_tdata[63:32];
    in_item.pos[2]     = in_tdata[95:64];
    in_item.nrm[0]     = in_tdata[127:96];
    in_item.nrm[1]     = in_tdata[159:128];
    in_item.nrm[2]     = in_tdata[191:160];
    in_item.joint_set  = in_tdata[215:192];
    in_item.weight_set = in_tdata[279:216];
    in_item.load_joint = in_tdata[285:280];
    in_item.load_slot  = in_tdata[290:286];
    in_item.load_value = in_tdata[322:291];
  end

  assign in_tready = (cnt_r != (PW+1)'(IQ_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

FILE: rtl/lbs_palette.sv
module lbs_palette import lbs_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [JW-1:0]     wr_joint,
  input  logic [4:0]        wr_slot,
  input  logic [31:0]       wr_value,
  input  logic              rd_en,
  input  logic [JW-1:0]     rd_joint,
  output logic [15:0][31:0] pose_q,
  output logic [15:0][31:0] ib_q
);

  for (genvar e = 0; e < 16; e++) begin : g_bank
    logic [31:0] pose_mem [MAX_JOINTS];
    logic [31:0] ib_mem   [MAX_JOINTS];

    always_ff @(posedge clk) begin
      if (wr_en && wr_slot[3:0] == 4'(e)) begin
        if (wr_slot[4]) begin
          ib_mem[wr_joint] <= wr_value;
        end else begin
          pose_mem[wr_joint] <= wr_value;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        pose_q[e] <= pose_mem[rd_joint];
        ib_q[e]   <= ib_mem[rd_joint];
      end
    end
  end

endmodule

FILE: rtl/lbs_back.sv
module lbs_back import lbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               pal_wr_en,
  output logic [JW-1:0]      pal_wr_joint,
  output logic [4:0]         pal_wr_slot,
  output logic [31:0]        pal_wr_value,
  output logic               pal_rd_en,
  output logic [JW-1:0]      pal_rd_joint,
  input  logic [15:0][31:0]  pose_q,
  input  logic [15:0][31:0]  ib_q,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  localparam int OW = $clog2(OQ_DEPTH);

  logic [1:0]      phase_r, phase_nxt;
  logic [OW:0]     cnt_r, cnt_nxt;
  logic            is_load, is_skin, issue, start;
  logic [5:0]      jidx;
  logic [15:0]     wgt;
  logic            j_ok;

  tag_t t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r;
  tag_t t1_nxt, t6_nxt;

  logic signed [63:0] prod_r [16][4];
  logic signed [31:0] elem_r [16], elem_nxt [16];
  logic signed [48:0] wp_r [16], wp_nxt [16];
  logic signed [51:0] acc_r [16], acc_nxt [16];
  logic signed [31:0] skin_r [16], skin_nxt [16];
  logic signed [63:0] xpp_r [3][3], xpn_r [3][3];
  logic signed [31:0] trans_r [3];
  logic [OUT_W-1:0]   res_nxt;

  logic [OUT_W-1:0] ofifo_r [OQ_DEPTH];
  logic [OW-1:0]    owp_r, orp_r;
  logic [OW:0]      oc_r, oc_nxt;
  logic             opush, opop;

  // sequencer
  assign is_load = q_valid && (q_item.opcode == OP_LOAD);
  assign is_skin = q_valid && (q_item.opcode == OP_SKIN);
  assign issue   = is_skin && ((phase_r != 2'd0) || (cnt_r < (OW+1)'(OQ_DEPTH)));
  assign start   = issue && (phase_r == 2'd0);
  assign q_pop   = is_load || (issue && phase_r == 2'd3);
  assign jidx    = q_item.joint_set[phase_r*6 +: 6];
  assign wgt     = q_item.weight_set[phase_r*16 +: 16];
  assign j_ok    = (int'(jidx) < MAX_JOINTS);

  assign pal_wr_en    = is_load && (int'(q_item.load_joint) < MAX_JOINTS);
  assign pal_wr_joint = JW'(q_item.load_joint);
  assign pal_wr_slot  = q_item.load_slot;
  assign pal_wr_value = q_item.load_value;
  assign pal_rd_en    = issue;
  assign pal_rd_joint = JW'(jidx);

  assign opush = t7_r.vld;
  assign opop  = out_tvalid && out_tready;

  always_comb begin
    phase_nxt    = issue ? phase_r + 2'd1 : phase_r;
    cnt_nxt      = cnt_r + (OW+1)'(start) - (OW+1)'(opop);
    oc_nxt       = oc_r + (OW+1)'(opush) - (OW+1)'(opop);
    t1_nxt.vld   = issue;
    t1_nxt.first = (phase_r == 2'd0);
    t1_nxt.last  = (phase_r == 2'd3);
    t1_nxt.wt    = j_ok ? wgt : 16'd0;
    t1_nxt.pos   = q_item.pos;
    t1_nxt.nrm   = q_item.nrm;
    t6_nxt       = t5_r;
    t6_nxt.vld   = t5_r.vld && t5_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      cnt_r   <= '0;
      oc_r    <= '0;
      owp_r   <= '0;
      orp_r   <= '0;
      t1_r    <= '0;
      t2_r    <= '0;
      t3_r    <= '0;
      t4_r    <= '0;
      t5_r    <= '0;
      t6_r    <= '0;
      t7_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      oc_r    <= oc_nxt;
      owp_r   <= opush ? owp_r + 1'b1 : owp_r;
      orp_r   <= opop ? orp_r + 1'b1 : orp_r;
      t1_r    <= t1_nxt;
      t2_r    <= t1_r;
      t3_r    <= t2_r;
      t4_r    <= t3_r;
      t5_r    <= t4_r;
      t6_r    <= t6_nxt;
      t7_r    <= t6_r;
    end
  end

  // datapath
  always_comb begin
    logic signed [51:0] s;
    for (int e = 0; e < 16; e++) begin
      s = '0;
      for (int i = 0; i < 4; i++) begin
        s = s + 52'(rnd16(prod_r[e][i]));
      end
      elem_nxt[e] = sat32(s);
      wp_nxt[e]   = elem_r[e] * $signed({1'b0, t3_r.wt});
      acc_nxt[e]  = (t4_r.first ? 52'sd0 : acc_r[e]) + 52'(wp_r[e]);
      skin_nxt[e] = sat32(52'(rnd15(acc_r[e])));
    end
  end

  always_comb begin
    logic signed [51:0] sp, sn;
    for (int r = 0; r < 3; r++) begin
      sp = 52'(trans_r[r]);
      sn = '0;
      for (int c = 0; c < 3; c++) begin
        sp = sp + 52'(rnd16(xpp_r[r][c]));
        sn = sn + 52'(rnd16(xpn_r[r][c]));
      end
      res_nxt[r*32 +: 32]     = sat32(sp);
      res_nxt[96+r*32 +: 32]  = sat32(sn);
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 16; e++) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[e][i] <= $signed(pose_q[(e/4)*4+i]) * $signed(ib_q[i*4+(e%4)]);
      end
      elem_r[e] <= elem_nxt[e];
      wp_r[e]   <= wp_nxt[e];
      if (t4_r.vld) begin
        acc_r[e] <= acc_nxt[e];
      end
      skin_r[e] <= skin_nxt[e];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        xpp_r[r][c] <= skin_r[r*4+c] * $signed(t6_r.pos[c]);
        xpn_r[r][c] <= skin_r[r*4+c] * $signed(t6_r.nrm[c]);
      end
      trans_r[r] <= skin_r[r*4+3];
    end
    if (opush) begin
      ofifo_r[owp_r] <= res_nxt;
    end
  end

  assign out_tvalid = (oc_r != '0);
  assign out_tdata  = ofifo_r[orp_r];

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (OW+1)'(OQ_DEPTH)) else $error("credit count over queue depth");
  a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r <= cnt_r) else $error("result queue holds more than reserved");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    opush |-> oc_r < (OW+1)'(OQ_DEPTH) || opop) else $error("result queue overflow");
  a_vertex_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && is_skin) |-> phase_r == 2'd3) else $error("vertex popped mid-sequence");
  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 2'd0) |-> is_skin) else $error("vertex left queue mid-sequence");

endmodule

FILE: rtl/linear_blend_skinning.sv
// Vertex word: four influences, one palette read and 4x4 matrix product per cycle once a result slot is reserved.
// Load word: popped without stalling, written to the palette banks in order with vertex words.
// Result queue of 4 words; the input queue of 4 words keeps accepting until full while results stall.
// Reset empties both queues and the pipeline; palettes are not cleared.
module linear_blend_skinning import lbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, joint_set, weight_set,
  // load_joint, load_slot, load_value, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  // opcode
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // skinned_pos_x, _y, _z, skinned_nrm_x, _y, _z
  output logic [OUT_W-1:0] out_tdata
);

  logic              q_valid, q_pop;
  item_t             q_item;
  logic              wr_en, rd_en;
  logic [JW-1:0]     wr_joint, rd_joint;
  logic [4:0]        wr_slot;
  logic [31:0]       wr_value;
  logic [15:0][31:0] pose_q, ib_q;

  lbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  lbs_palette u_palette (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_joint (wr_joint),
    .wr_slot  (wr_slot),
    .wr_value (wr_value),
    .rd_en    (rd_en),
    .rd_joint (rd_joint),
    .pose_q   (pose_q),
    .ib_q     (ib_q)
  );

  lbs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .pal_wr_en    (wr_en),
    .pal_wr_joint (wr_joint),
    .pal_wr_slot  (wr_slot),
    .pal_wr_value (wr_value),
    .pal_rd_en    (rd_en),
    .pal_rd_joint (rd_joint),
    .pose_q       (pose_q),
    .ib_q         (ib_q),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lbs_pkg::*;

  typedef struct {
    logic [31:0] px, py, pz, nx, ny, nz;
  } vtx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  linear_blend_skinning uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [31:0] pose_mem [MAX_JOINTS*16];
  logic signed [31:0] ibind_mem [MAX_JOINTS*16];
  bit pose_written [MAX_JOINTS*16];
  bit ibind_written [MAX_JOINTS*16];
  vtx_res_t skinned_q[$];

  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  int n_vertices = 0;
  int n_loads = 0;
  int n_checked = 0;

  function automatic logic signed [63:0] round_q(input logic signed [63:0] v, input int s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic vtx_res_t skin_vertex(input logic [31:0] pos [3],
                                           input logic [31:0] nrm [3],
                                           input logic [23:0] jset,
                                           input logic [63:0] wset);
    logic signed [63:0] acc [16];
    logic signed [63:0] skin [16];
    logic signed [63:0] s, w, a, b, sp, sn;
    logic [31:0] o [6];
    int j, base;
    vtx_res_t res;
    foreach (acc[i]) acc[i] = 0;
    for (int k = 0; k < 4; k++) begin
      j = int'(jset[6*k +: 6]);
      w = {48'd0, wset[16*k +: 16]};
      if (j < MAX_JOINTS) begin
        base = j * 16;
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            s = 0;
            for (int i = 0; i < 4; i++) begin
              a = pose_mem[base + r*4 + i];
              b = ibind_mem[base + i*4 + c];
              s += round_q(a * b, 16);
            end
            acc[r*4 + c] += clamp32(s) * w;
          end
        end
      end
    end
    foreach (skin[i]) skin[i] = clamp32(round_q(acc[i], 15));
    for (int r = 0; r < 3; r++) begin
      sp = skin[r*4 + 3];
      sn = 0;
      for (int c = 0; c < 3; c++) begin
        sp += round_q(skin[r*4 + c] * $signed({{32{pos[c][31]}}, pos[c]}), 16);
        sn += round_q(skin[r*4 + c] * $signed({{32{nrm[c][31]}}, nrm[c]}), 16);
      end
      o[r] = 32'(clamp32(sp));
      o[3 + r] = 32'(clamp32(sn));
    end
    res.px = o[0]; res.py = o[1]; res.pz = o[2];
    res.nx = o[3]; res.ny = o[4]; res.nz = o[5];
    return res;
  endfunction

  // in_tvalid stays high after an accepted word; idle cycles and drain drop it
  task automatic send_word(input op_t op, input logic [IN_W-1:0] data);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_elem(input logic [5:0] jnt, input logic [4:0] slot,
                           input logic [31:0] val);
    logic [IN_W-1:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    d[IN_W-1:323] = '0;
    d[280 +: 6] = jnt;
    d[286 +: 5] = slot;
    d[291 +: 32] = val;
    if (jnt < MAX_JOINTS) begin
      if (slot < 16) begin
        pose_mem[jnt*16 + slot] = val;
        pose_written[jnt*16 + slot] = 1'b1;
      end else begin
        ibind_mem[jnt*16 + slot - 16] = val;
        ibind_written[jnt*16 + slot - 16] = 1'b1;
      end
    end
    n_loads++;
    send_word(OP_LOAD, d);
  endtask

  task automatic load_joint_mats(input logic [5:0] jnt, input int mode);
    logic [31:0] v;
    for (int s = 0; s < 32; s++) begin
      case (mode)
        0: v = ((s % 16) % 5 == 0) ? 32'h0001_0000 : 32'h0;
        1: v = $urandom_range(32'h0003_0000) - 32'h0001_8000;
        2: v = ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
        default: v = $urandom;
      endcase
      load_elem(jnt, s[4:0], v);
    end
  endtask

  function automatic bit joint_ready(input int j);
    for (int e = 0; e < 16; e++)
      if (!pose_written[j*16 + e] || !ibind_written[j*16 + e]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic skin_one(input logic [31:0] pos [3], input logic [31:0] nrm [3],
                          input logic [23:0] jset, input logic [63:0] wset);
    logic [IN_W-1:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    d[IN_W-1:323] = '0;
    d[0 +: 32] = pos[0]; d[32 +: 32] = pos[1]; d[64 +: 32] = pos[2];
    d[96 +: 32] = nrm[0]; d[128 +: 32] = nrm[1]; d[160 +: 32] = nrm[2];
    d[192 +: 24] = jset;
    d[216 +: 64] = wset;
    skinned_q.push_back(skin_vertex(pos, nrm, jset, wset));
    n_vertices++;
    send_word(OP_SKIN, d);
  endtask

  // joints picked among written ones; out-of-range indices allowed
  task automatic skin_random(input int style);
    logic [31:0] pos [3], nrm [3];
    logic [23:0] jset;
    logic [63:0] wset;
    int j;
    for (int c = 0; c < 3; c++) begin
      if (style == 0) begin
        pos[c] = $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
        nrm[c] = $urandom_range(32'h0001_ffff) - 32'h0001_0000;
      end else begin
        pos[c] = $urandom;
        nrm[c] = $urandom;
      end
    end
    for (int k = 0; k < 4; k++) begin
      do j = $urandom_range(63);
      while (j < MAX_JOINTS && !joint_ready(j));
      jset[6*k +: 6] = 6'(j);
      wset[16*k +: 16] = (style == 0) ? 16'($urandom_range(16'h2000))
                                      : 16'($urandom_range(16'hffff));
    end
    skin_one(pos, nrm, jset, wset);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (skinned_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    vtx_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (skinned_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        e = skinned_q.pop_front();
        n_checked++;
        if (out_tdata[0 +: 32] !== e.px) begin
          $error("skinned_pos_x exp %h got %h", e.px, out_tdata[0 +: 32]); errors++;
        end
        if (out_tdata[32 +: 32] !== e.py) begin
          $error("skinned_pos_y exp %h got %h", e.py, out_tdata[32 +: 32]); errors++;
        end
        if (out_tdata[64 +: 32] !== e.pz) begin
          $error("skinned_pos_z exp %h got %h", e.pz, out_tdata[64 +: 32]); errors++;
        end
        if (out_tdata[96 +: 32] !== e.nx) begin
          $error("skinned_nrm_x exp %h got %h", e.nx, out_tdata[96 +: 32]); errors++;
        end
        if (out_tdata[128 +: 32] !== e.ny) begin
          $error("skinned_nrm_y exp %h got %h", e.ny, out_tdata[128 +: 32]); errors++;
        end
        if (out_tdata[160 +: 32] !== e.nz) begin
          $error("skinned_nrm_z exp %h got %h", e.nz, out_tdata[160 +: 32]); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  task automatic test_directed();
    logic [31:0] pos [3], nrm [3];
    load_joint_mats(6'd0, 0);
    load_joint_mats(6'd1, 1);
    load_joint_mats(6'd63, 2);
    load_elem(6'd63, 5'd0, 32'h0002_0000);
    pos = '{32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
    nrm = '{32'h0, 32'h0001_0000, 32'h0};
    skin_one(pos, nrm, {6'd0, 6'd0, 6'd0, 6'd0}, {16'h0, 16'h0, 16'h0, 16'h8000});
    skin_one(pos, nrm, {6'd1, 6'd0, 6'd1, 6'd0}, {16'h2000, 16'h2000, 16'h2000, 16'h2000});
    pos = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    nrm = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    skin_one(pos, nrm, {6'd63, 6'd63, 6'd63, 6'd63}, 64'hffff_ffff_ffff_ffff);
    skin_one(pos, nrm, {6'd0, 6'd1, 6'd63, 6'd0}, 64'h0000_0000_0000_0000);
    skin_one(pos, nrm, {6'd0, 6'd0, 6'd1, 6'd63}, 64'h8000_8000_8000_8000);
    pos = '{32'h0, 32'h0, 32'h0};
    skin_one(pos, pos, {6'd1, 6'd1, 6'd1, 6'd1}, 64'h0001_7fff_8001_ffff);
    wait_drain();
  endtask

  task automatic test_random(input int n_items, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) < 2) begin
        load_elem(6'($urandom_range(63)), 5'($urandom_range(31)), $urandom);
      end else begin
        skin_random($urandom_range(3) == 0);
      end
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 300;
    for (int i = 0; i < 20; i++) skin_random(0);
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int j = 2; j < 6; j++) load_joint_mats(j[5:0], (j % 2) ? 1 : 3);
    test_random(50, 0, 0);
    test_random(50, 69, 0);
    test_random(50, 0, 69);
    test_random(50, 15, 15);
    test_backpressure();
    $display("Covered %0d vertex words and %0d load words, %0d results checked,",
             n_vertices, n_loads, n_checked);
    $display("with idle, stall, mixed and long-backpressure phases and saturating values.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
